[hw/rtl/bfpp_pkg.sv]
// ----------------------------------------------------------------------------
// bfpp_pkg - shared types and constants of the boot frame page programmer
// Frame byte codes, result kinds, the command passed from the frame parser to
// the executor, and the page buffer write request.
// ----------------------------------------------------------------------------
`default_nettype none

package bfpp_pkg;

	localparam int unsigned PAGE_SIZE_LOG2_DEF = 7;
	localparam int unsigned PAGE_IDX_MAX_W     = 7;   // largest page is 128 bytes
	localparam int unsigned STEP_W             = 6;   // up to 38 results per command
	localparam int unsigned QDEPTH             = 2;
	localparam int unsigned QPTR_W             = 1;

	localparam logic [31:0] BASE_RESET = 32'h0800_0400;

	localparam logic [7:0] SIZE_LONG  = 8'hFF;
	localparam logic [7:0] TYPE_RESET = 8'hC7;
	localparam logic [7:0] TYPE_PAGE  = 8'h88;
	localparam logic [7:0] ACK_LEN    = 8'h02;
	localparam logic [7:0] ACK_CODE   = 8'h08;
	localparam logic [7:0] ERR_FLAG   = 8'h10;
	localparam logic [7:0] ERR_CODE   = 8'h01;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_REPLY = 2'd0;
	localparam kind_t KIND_ERASE = 2'd1;
	localparam kind_t KIND_WRITE = 2'd2;
	localparam kind_t KIND_RESET = 2'd3;

	typedef logic [1:0] op_t;
	localparam op_t OP_NONE = 2'd0;
	localparam op_t OP_ERR  = 2'd1;
	localparam op_t OP_RST  = 2'd2;
	localparam op_t OP_PAGE = 2'd3;

	typedef struct packed {
		op_t        op;
		logic [7:0] size;
		logic [7:0] page_high;
		logic [7:0] page_low;
	} cmd_t;

	typedef struct packed {
		logic                      en;
		logic [PAGE_IDX_MAX_W-1:0] idx;
		logic [7:0]                data;
	} buf_wr_t;

	typedef struct packed {
		logic page_done;
		logic page_active;
	} exec_status_t;

endpackage

`default_nettype wire

[hw/rtl/bfpp_frame_parser.sv]
// ----------------------------------------------------------------------------
// bfpp_frame_parser - front end: frame byte parsing
// Tracks position, length, running XOR and header fields, sends payload bytes
// to the page buffer; each bad-check, reset or page frame ends in one command.
// ----------------------------------------------------------------------------
`default_nettype none

module bfpp_frame_parser #(
	parameter int unsigned PAGE_SIZE_LOG2 = bfpp_pkg::PAGE_SIZE_LOG2_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic [7:0]             rx_byte,
	output logic                        q_push,
	output bfpp_pkg::cmd_t              q_cmd,
	input  wire logic                   q_full,
	output bfpp_pkg::buf_wr_t           buf_wr,
	input  wire bfpp_pkg::exec_status_t exec_st,
	output logic                        page_busy
);

	localparam logic [8:0] PAGE_BYTES = 9'(1 << PAGE_SIZE_LOG2);

	logic [8:0] pos_q, len_q;
	logic [7:0] xor_q, size_q, type_q, ph_q, pl_q;
	logic       page_busy_q;

	logic       acc, first, frame_end;
	logic [8:0] len_n, pos_inc;
	logic [7:0] xor_n, size_n, type_n, ph_n, pl_n;
	bfpp_pkg::op_t op_n;

	assign full      = page_busy_q | q_full;
	assign acc       = push & ~full;
	assign first     = (pos_q == 9'd0);
	assign page_busy = page_busy_q;

	always_comb begin
		len_n  = len_q;
		size_n = size_q;
		xor_n  = xor_q ^ rx_byte;
		if (first) begin
			size_n = rx_byte;
			xor_n  = rx_byte;
			len_n  = ((rx_byte == bfpp_pkg::SIZE_LONG) ? PAGE_BYTES + 9'd2 : {1'b0, rx_byte})
			         + 9'd3;
		end
		type_n = (pos_q == 9'd1) ? rx_byte : type_q;
		ph_n   = (pos_q == 9'd2) ? rx_byte : ph_q;
		pl_n   = (pos_q == 9'd3) ? rx_byte : pl_q;
	end

	assign pos_inc   = pos_q + 9'd1;
	assign frame_end = (pos_inc >= len_n);

	always_comb begin
		priority if (xor_n != 8'd0)                  op_n = bfpp_pkg::OP_ERR;
		else if (type_n == bfpp_pkg::TYPE_RESET)     op_n = bfpp_pkg::OP_RST;
		else if (type_n == bfpp_pkg::TYPE_PAGE)      op_n = bfpp_pkg::OP_PAGE;
		else                                         op_n = bfpp_pkg::OP_NONE;
	end

	assign q_push          = acc & frame_end & (op_n != bfpp_pkg::OP_NONE);
	assign q_cmd.op        = op_n;
	assign q_cmd.size      = size_n;
	assign q_cmd.page_high = ph_n;
	assign q_cmd.page_low  = pl_n;

	// payload bytes beyond the page only feed the XOR
	assign buf_wr.en   = acc & (pos_q >= 9'd4) & (pos_q < PAGE_BYTES + 9'd4);
	assign buf_wr.idx  = bfpp_pkg::PAGE_IDX_MAX_W'(pos_q - 9'd4);
	assign buf_wr.data = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			xor_q  <= '0;
			size_q <= '0;
			type_q <= '0;
			ph_q   <= '0;
			pl_q   <= '0;
		end else if (acc) begin
			pos_q  <= frame_end ? 9'd0 : pos_inc;
			len_q  <= len_n;
			xor_q  <= xor_n;
			size_q <= size_n;
			type_q <= type_n;
			ph_q   <= ph_n;
			pl_q   <= pl_n;
		end
	end

	// the buffer is owned by the executor until the acknowledge is out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_busy_q <= 1'b0;
		end else if (q_push && q_cmd.op == bfpp_pkg::OP_PAGE) begin
			page_busy_q <= 1'b1;
		end else if (exec_st.page_done) begin
			page_busy_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/bfpp_cmd_queue.sv]
// ----------------------------------------------------------------------------
// bfpp_cmd_queue - command queue between parser and executor
// Two-entry FIFO of frame-end commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bfpp_cmd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_en,
	input  wire bfpp_pkg::cmd_t wr_cmd,
	output logic                q_full,
	output logic                rd_valid,
	output bfpp_pkg::cmd_t      rd_cmd,
	input  wire logic           rd_en
);

	localparam int unsigned CNT_W = bfpp_pkg::QPTR_W + 1;

	bfpp_pkg::cmd_t                  entry_q [bfpp_pkg::QDEPTH];
	logic [bfpp_pkg::QPTR_W-1:0]     wp_q, rp_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            do_wr, do_rd;

	assign q_full   = (cnt_q == CNT_W'(bfpp_pkg::QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = entry_q[rp_q];
	assign do_wr    = wr_en & ~q_full;
	assign do_rd    = rd_en & rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/bfpp_executor.sv]
// ----------------------------------------------------------------------------
// bfpp_executor - back end: command execution and page buffer
// Holds the page buffer as 32-bit rows and steps each command through its
// results into a one-entry output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfpp_executor #(
	parameter int unsigned PAGE_SIZE_LOG2 = bfpp_pkg::PAGE_SIZE_LOG2_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire bfpp_pkg::cmd_t    q_cmd,
	output logic                   q_pop,
	input  wire logic [31:0]       base_addr,
	input  wire bfpp_pkg::buf_wr_t buf_wr,
	output bfpp_pkg::exec_status_t exec_st,
	output logic                   empty,
	input  wire logic              pop,
	output logic [1:0]             kind,
	output logic [7:0]             reply_byte,
	output logic [31:0]            flash_address,
	output logic [31:0]            flash_word,
	output logic                   last
);

	localparam int unsigned BYTES = 1 << PAGE_SIZE_LOG2;
	localparam int unsigned ROWS  = 1 << (PAGE_SIZE_LOG2 - 2);
	localparam int unsigned ROW_W = (PAGE_SIZE_LOG2 > 2) ? PAGE_SIZE_LOG2 - 2 : 1;
	localparam int unsigned SW    = bfpp_pkg::STEP_W;
	localparam logic [SW-1:0] FIRST_ACK = SW'(ROWS + 1);
	localparam logic [SW-1:0] PAGE_END  = SW'(ROWS + 5);
	localparam logic [SW-1:0] ERR_END   = SW'(3);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	logic [31:0]       mem_q [ROWS];
	logic [BYTES-1:0]  vld_q;
	logic [31:0]       rd_data_s1;
	logic [3:0]        rd_vld_s1;
	logic              rd_fresh_q;

	logic              busy_q;
	bfpp_pkg::op_t     op_q;
	logic [7:0]        size_q, ph_q, pl_q;
	logic [31:0]       addr_q;
	logic [SW-1:0]     step_q;
	logic [ROW_W-1:0]  widx_q;

	logic              ovld_q;

	logic              load, is_word, final_step, emit, ack_wr, widx_chg;
	logic [2:0]        ack_i;
	logic [7:0]        err_b, ck;
	logic [31:0]       word;
	logic [SW-1:0]     end_step;
	bfpp_pkg::kind_t   r_kind;
	logic [7:0]        r_byte;
	logic [31:0]       r_addr, r_word;

	logic                      we;
	logic [PAGE_SIZE_LOG2-1:0] w_idx;
	logic [ROW_W-1:0]          w_row;
	logic [1:0]                w_lane;
	logic [7:0]                w_data;

	assign load    = ~busy_q & q_valid;
	assign q_pop   = load;
	assign is_word = (op_q == bfpp_pkg::OP_PAGE) && (step_q != '0) && (step_q < FIRST_ACK);

	always_comb begin
		unique case (op_q)
			bfpp_pkg::OP_ERR:  end_step = ERR_END;
			bfpp_pkg::OP_PAGE: end_step = PAGE_END;
			default:           end_step = '0;
		endcase
	end

	assign final_step = (step_q == end_step);
	assign emit       = busy_q & (~ovld_q | pop) & (~is_word | rd_fresh_q);
	assign ack_wr     = emit & (op_q == bfpp_pkg::OP_PAGE) & final_step;
	assign widx_chg   = load | (emit & is_word & (widx_q != LAST_ROW));

	assign err_b = size_q | bfpp_pkg::ERR_FLAG;
	assign ck    = bfpp_pkg::ACK_LEN ^ bfpp_pkg::ACK_CODE ^ ph_q ^ pl_q;
	assign ack_i = 3'(step_q - FIRST_ACK);

	// bytes never written since reset read as zero
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			word[8*l +: 8] = rd_vld_s1[l] ? rd_data_s1[8*l +: 8] : 8'd0;
		end
	end

	always_comb begin
		r_kind = bfpp_pkg::KIND_REPLY;
		r_byte = 8'd0;
		r_addr = 32'd0;
		r_word = 32'd0;
		unique case (op_q)
			bfpp_pkg::OP_ERR: begin
				r_byte = (step_q == '0 || step_q == ERR_END) ? err_b : bfpp_pkg::ERR_CODE;
			end
			bfpp_pkg::OP_PAGE: begin
				if (step_q == '0) begin
					r_kind = bfpp_pkg::KIND_ERASE;
					r_addr = addr_q;
				end else if (is_word) begin
					r_kind = bfpp_pkg::KIND_WRITE;
					r_addr = addr_q;
					r_word = word;
				end else begin
					unique case (ack_i)
						3'd0:    r_byte = bfpp_pkg::ACK_LEN;
						3'd1:    r_byte = bfpp_pkg::ACK_CODE;
						3'd2:    r_byte = ph_q;
						3'd3:    r_byte = pl_q;
						default: r_byte = ck;
					endcase
				end
			end
			default: begin
				r_kind = bfpp_pkg::KIND_RESET;
			end
		endcase
	end

	// single write port: parser bytes, or the acknowledge check byte into entry zero
	assign we     = buf_wr.en | ack_wr;
	assign w_idx  = ack_wr ? '0 : buf_wr.idx[PAGE_SIZE_LOG2-1:0];
	assign w_data = ack_wr ? ck : buf_wr.data;
	assign w_row  = ROW_W'(w_idx >> 2);
	assign w_lane = w_idx[1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[w_row][8*w_lane +: 8] <= w_data;
		end
		rd_data_s1 <= mem_q[widx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_vld_s1  <= '0;
			rd_fresh_q <= 1'b0;
		end else begin
			if (we) vld_q[w_idx] <= 1'b1;
			rd_vld_s1  <= vld_q[4*widx_q +: 4];
			rd_fresh_q <= ~widx_chg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			op_q   <= bfpp_pkg::OP_NONE;
			step_q <= '0;
			widx_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			op_q   <= q_cmd.op;
			step_q <= '0;
			widx_q <= '0;
		end else if (emit) begin
			if (final_step) busy_q <= 1'b0;
			else            step_q <= step_q + 1'b1;
			if (widx_chg)   widx_q <= widx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			size_q <= q_cmd.size;
			ph_q   <= q_cmd.page_high;
			pl_q   <= q_cmd.page_low;
			addr_q <= base_addr
			          + 32'({q_cmd.page_high, q_cmd.page_low, PAGE_SIZE_LOG2'(0)});
		end else if (emit && is_word) begin
			addr_q <= addr_q + 32'd4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (emit) begin
			ovld_q <= 1'b1;
		end else if (pop) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind          <= r_kind;
			reply_byte    <= r_byte;
			flash_address <= r_addr;
			flash_word    <= r_word;
			last          <= final_step;
		end
	end

	assign empty               = ~ovld_q;
	assign exec_st.page_done   = ack_wr;
	assign exec_st.page_active = busy_q & (op_q == bfpp_pkg::OP_PAGE);

endmodule

`default_nettype wire

[hw/rtl/boot_frame_page_programmer_core.sv]
// ----------------------------------------------------------------------------
// boot_frame_page_programmer_core - boot frame parser and page programmer
// Parser, command queue and executor with the firmware base address register.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per clock while full is low. At the last byte of
// a frame a command is queued: a bad check gives four reply bytes, a reset
// frame one reset request, a page frame an erase, one word write per 32-bit
// word of the page and five acknowledge bytes. The executor produces at most
// one result per cycle, and each page word after the first waits for a fresh
// page buffer read, so a page frame keeps full high after its last byte while
// the buffer is read out, until the acknowledge check byte is out; result
// stalls lengthen that. Error and reset frames do not hold off input unless
// the two-entry command queue is full. The address register may be written
// only while the block is idle.
`default_nettype none

module boot_frame_page_programmer_core #(
	parameter int unsigned PAGE_SIZE_LOG2 = bfpp_pkg::PAGE_SIZE_LOG2_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  rx_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       kind,
	output logic [7:0]       reply_byte,
	output logic [31:0]      flash_address,
	output logic [31:0]      flash_word,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	logic [31:0]            base_q;
	logic                   q_push, q_full, q_valid, q_pop, pg_busy;
	bfpp_pkg::cmd_t         f_cmd, h_cmd;
	bfpp_pkg::buf_wr_t      buf_wr;
	bfpp_pkg::exec_status_t exec_st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= bfpp_pkg::BASE_RESET;
		end else if (cfg_valid) begin
			base_q <= cfg_data;
		end
	end

	bfpp_frame_parser #(.PAGE_SIZE_LOG2(PAGE_SIZE_LOG2)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_byte   (rx_byte),
		.q_push    (q_push),
		.q_cmd     (f_cmd),
		.q_full    (q_full),
		.buf_wr    (buf_wr),
		.exec_st   (exec_st),
		.page_busy (pg_busy)
	);

	bfpp_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_cmd   (f_cmd),
		.q_full   (q_full),
		.rd_valid (q_valid),
		.rd_cmd   (h_cmd),
		.rd_en    (q_pop)
	);

	bfpp_executor #(.PAGE_SIZE_LOG2(PAGE_SIZE_LOG2)) u_exec (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_cmd         (h_cmd),
		.q_pop         (q_pop),
		.base_addr     (base_q),
		.buf_wr        (buf_wr),
		.exec_st       (exec_st),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.reply_byte    (reply_byte),
		.flash_address (flash_address),
		.flash_word    (flash_word),
		.last          (last)
	);

	// a command is never dropped at the queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into full queue");

	// the parser never writes the buffer while a page is being read out
	a_no_buf_wr_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		buf_wr.en |-> !pg_busy)
		else $error("page buffer written during page programming");

	// executor working on a page implies the parser holds the buffer lock
	a_page_lock_held: assert property (@(posedge clk) disable iff (!arst_n)
		exec_st.page_active |-> pg_busy)
		else $error("page command active without buffer lock");

	// lock releases only once the acknowledge check byte has gone out
	a_lock_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pg_busy) |-> $past(exec_st.page_done))
		else $error("buffer lock released early");

endmodule

`default_nettype wire
